### sv/pis_pkg.sv
// Shared types, constants and register codes of the price indicator signal unit.
`timescale 1ns / 1ps
package pis_pkg;

   localparam int PRICE_W     = 32;
   localparam int WIN_DEPTH   = 32;
   localparam int ADDR_W      = $clog2(WIN_DEPTH);
   localparam int CNT_W       = 5;
   localparam int CNT_MAX     = 31;
   localparam int SUM_W       = 37;
   localparam int WEIGHT_W    = 12;
   localparam int LEVEL_W     = 7;
   localparam int STRENGTH_W  = 16;
   localparam int DECISION_W  = 2;
   localparam int DIVD_W      = PRICE_W + WEIGHT_W;
   localparam int PROD_W      = SUM_W + 1 + LEVEL_W;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam int DEF_TREND_LENGTH = 20;
   localparam int DEF_RSI_LENGTH   = 14;
   localparam int DEF_MOMENTUM_LAG = 5;

   localparam logic [DECISION_W-1:0] DEC_HOLD = 2'd0;
   localparam logic [DECISION_W-1:0] DEC_BUY  = 2'd1;
   localparam logic [DECISION_W-1:0] DEC_SELL = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_TREND_WEIGHT     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_RSI_WEIGHT       = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MOMENTUM_GAIN    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_OVERSOLD_LEVEL   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_OVERBOUGHT_LEVEL = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_BUY_LEVEL        = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_SELL_LEVEL       = 3'd6;

   typedef struct packed {
      logic [WEIGHT_W-1:0]          trend_weight;
      logic [WEIGHT_W-1:0]          rsi_weight;
      logic [WEIGHT_W-1:0]          momentum_gain;
      logic [LEVEL_W-1:0]           oversold_level;
      logic [LEVEL_W-1:0]           overbought_level;
      logic signed [STRENGTH_W-1:0] buy_level;
      logic signed [STRENGTH_W-1:0] sell_level;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      trend_weight:     12'd1229,
      rsi_weight:       12'd1638,
      momentum_gain:    12'd1229,
      oversold_level:   7'd30,
      overbought_level: 7'd70,
      buy_level:        16'sd2048,
      sell_level:       -16'sd2048
   };

   // One classified item handed from front to back
   typedef struct packed {
      logic                ready;
      logic                trend_up;
      logic                below;
      logic                above;
      logic                mom_en;
      logic                mom_neg;
      logic [DIVD_W-1:0]   dividend;
      logic [PRICE_W-1:0]  divisor;
   } task_type;

endpackage

### sv/price_indicator_signal_unit.sv
// Top level of the price indicator signal unit: CSRs, front end, task queue, back end.
`timescale 1ns / 1ps
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+----------------------------------------
//   req      | in        | req_valid / req_ready | req_price (Q16.16)
//   rsp      | out       | rsp_valid / rsp_ready | rsp_ready_res, rsp_strength,
//            |           |                       | rsp_decision
//   csr      | in        | csr_we                | csr_addr, csr_wdata
//
// The front end handles one price at a time: five window reads through the single
// RAM read port, then update, evaluate and push. The back end runs the momentum
// divider, one quotient bit per cycle, only for ready items with momentum enabled,
// then registers the output; the divider sets the sustained rate.
// Synchronous active-high reset clears sums, counters, queue and output valid;
// window entries are always written before their values are used, so need no clearing.
// The queue lets the front take the next price while the back is still dividing
// or an item waits at the output.
module price_indicator_signal_unit #(
   parameter int TREND_LENGTH = pis_pkg::DEF_TREND_LENGTH,
   parameter int RSI_LENGTH   = pis_pkg::DEF_RSI_LENGTH,
   parameter int MOMENTUM_LAG = pis_pkg::DEF_MOMENTUM_LAG
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [pis_pkg::PRICE_W-1:0]        req_price,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_ready_res,
   output logic signed [pis_pkg::STRENGTH_W-1:0] rsp_strength,
   output logic [pis_pkg::DECISION_W-1:0]     rsp_decision,
   input  logic                               csr_we,
   input  logic [pis_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [pis_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pis_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     push_valid, push_full, pop_valid, pop;
   task_type push_data, pop_data;

   // register file; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_TREND_WEIGHT:     cfg_in.trend_weight     = csr_wdata[WEIGHT_W-1:0];
            REG_RSI_WEIGHT:       cfg_in.rsi_weight       = csr_wdata[WEIGHT_W-1:0];
            REG_MOMENTUM_GAIN:    cfg_in.momentum_gain    = csr_wdata[WEIGHT_W-1:0];
            REG_OVERSOLD_LEVEL:   cfg_in.oversold_level   = csr_wdata[LEVEL_W-1:0];
            REG_OVERBOUGHT_LEVEL: cfg_in.overbought_level = csr_wdata[LEVEL_W-1:0];
            REG_BUY_LEVEL:        cfg_in.buy_level        = $signed(csr_wdata);
            REG_SELL_LEVEL:       cfg_in.sell_level       = $signed(csr_wdata);
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pis_front #(
      .TREND_LENGTH(TREND_LENGTH),
      .RSI_LENGTH  (RSI_LENGTH),
      .MOMENTUM_LAG(MOMENTUM_LAG)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_price (req_price),
      .cfg       (cfg_ff),
      .push_valid(push_valid),
      .push_data (push_data),
      .push_full (push_full)
   );

   pis_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_data (push_data),
      .push_full (push_full),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop)
   );

   pis_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .pop_valid    (pop_valid),
      .pop_data     (pop_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_ready_res(rsp_ready_res),
      .rsp_strength (rsp_strength),
      .rsp_decision (rsp_decision)
   );
endmodule

### sv/pis_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### sv/pis_front.sv
// Front end: accepts prices, keeps the window and running sums, classifies each item.
`timescale 1ns / 1ps
module pis_front #(
   parameter int TREND_LENGTH = pis_pkg::DEF_TREND_LENGTH,
   parameter int RSI_LENGTH   = pis_pkg::DEF_RSI_LENGTH,
   parameter int MOMENTUM_LAG = pis_pkg::DEF_MOMENTUM_LAG
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [pis_pkg::PRICE_W-1:0] req_price,
   input  pis_pkg::cfg_type        cfg,
   output logic                    push_valid,
   output pis_pkg::task_type       push_data,
   input  logic                    push_full
);
   import pis_pkg::*;

   localparam logic [2:0] F_IDLE   = 3'd0;
   localparam logic [2:0] F_READ   = 3'd1;
   localparam logic [2:0] F_UPDATE = 3'd2;
   localparam logic [2:0] F_EVAL   = 3'd3;
   localparam logic [2:0] F_PUSH   = 3'd4;
   localparam int NUM_LAGS = 5;
   localparam logic [2:0] LAST_RD = 3'(NUM_LAGS);

   logic [2:0]         state_ff, state_in;
   logic [2:0]         rd_idx_ff, rd_idx_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   before_ff, before_in;
   logic [SUM_W-1:0]   trend_ff, trend_in;
   logic [SUM_W-1:0]   gain_ff, gain_in;
   logic [SUM_W-1:0]   loss_ff, loss_in;
   logic [PRICE_W-1:0] lag_ff [NUM_LAGS];
   task_type           task_ff, task_in;
   logic [PROD_W-1:0]  prod_g_ff, prod_g_in;
   logic [PROD_W-1:0]  prod_o_ff, prod_o_in;
   logic [PROD_W-1:0]  prod_b_ff, prod_b_in;
   logic               l_zero_ff, l_zero_in;

   logic               ram_we, ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [PRICE_W-1:0] ram_rdata;
   logic [ADDR_W-1:0]  lag_dist;

   // change terms for the RSI sums
   logic               add_en, drop_en, add_up, drop_up;
   logic [PRICE_W-1:0] add_mag, drop_mag;
   logic [SUM_W-1:0]   gain_add, gain_sub, loss_add, loss_sub;
   logic [SUM_W:0]     gl_sum;
   logic [PRICE_W-1:0] mom_diff;

   pis_ram #(.WIDTH(PRICE_W), .DEPTH(WIN_DEPTH)) u_window (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(pos_ff),
      .wr_data(price_ff),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_comb begin
      case (rd_idx_ff)
         3'd0:    lag_dist = ADDR_W'(TREND_LENGTH);
         3'd1:    lag_dist = ADDR_W'(1);
         3'd2:    lag_dist = ADDR_W'(RSI_LENGTH);
         3'd3:    lag_dist = ADDR_W'(RSI_LENGTH + 1);
         3'd4:    lag_dist = ADDR_W'(MOMENTUM_LAG);
         default: lag_dist = '0;
      endcase
   end

   assign ram_raddr = pos_ff - lag_dist;
   assign ram_re    = (state_ff == F_READ) && (rd_idx_ff < LAST_RD);
   assign ram_we    = (state_ff == F_UPDATE);
   assign req_ready = (state_ff == F_IDLE);

   assign add_en   = before_ff >= CNT_W'(1);
   assign drop_en  = before_ff >= CNT_W'(RSI_LENGTH + 1);
   assign add_up   = price_ff > lag_ff[1];
   assign add_mag  = add_up ? price_ff - lag_ff[1] : lag_ff[1] - price_ff;
   assign drop_up  = lag_ff[2] > lag_ff[3];
   assign drop_mag = drop_up ? lag_ff[2] - lag_ff[3] : lag_ff[3] - lag_ff[2];
   assign gain_add = (add_en && add_up) ? SUM_W'(add_mag) : '0;
   assign loss_add = (add_en && !add_up) ? SUM_W'(add_mag) : '0;
   assign gain_sub = (drop_en && drop_up) ? SUM_W'(drop_mag) : '0;
   assign loss_sub = (drop_en && !drop_up) ? SUM_W'(drop_mag) : '0;
   assign gl_sum   = {1'b0, gain_ff} + {1'b0, loss_ff};
   assign mom_diff = (price_ff < lag_ff[4]) ? lag_ff[4] - price_ff : price_ff - lag_ff[4];

   always_comb begin
      state_in  = state_ff;
      rd_idx_in = rd_idx_ff;
      price_in  = price_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      before_in = before_ff;
      trend_in  = trend_ff;
      gain_in   = gain_ff;
      loss_in   = loss_ff;
      task_in   = task_ff;
      prod_g_in = prod_g_ff;
      prod_o_in = prod_o_ff;
      prod_b_in = prod_b_ff;
      l_zero_in = l_zero_ff;
      push_valid = 1'b0;
      push_data  = task_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               price_in  = req_price;
               before_in = count_ff;
               rd_idx_in = '0;
               state_in  = F_READ;
            end
         end
         F_READ: begin
            rd_idx_in = rd_idx_ff + 3'd1;
            if (rd_idx_ff == LAST_RD) begin
               state_in = F_UPDATE;
            end
         end
         F_UPDATE: begin
            trend_in = trend_ff + SUM_W'(price_ff)
                     - ((before_ff >= CNT_W'(TREND_LENGTH)) ? SUM_W'(lag_ff[0]) : '0);
            gain_in  = gain_ff + gain_add - gain_sub;
            loss_in  = loss_ff + loss_add - loss_sub;
            count_in = (before_ff < CNT_W'(CNT_MAX)) ? before_ff + CNT_W'(1) : CNT_W'(CNT_MAX);
            pos_in   = pos_ff + ADDR_W'(1);
            state_in = F_EVAL;
         end
         F_EVAL: begin
            task_in.ready    = count_ff >= CNT_W'(TREND_LENGTH);
            task_in.trend_up = (SUM_W'(price_ff) * SUM_W'(TREND_LENGTH)) > trend_ff;
            task_in.below    = 1'b0;
            task_in.above    = 1'b0;
            task_in.mom_en   = (count_ff > CNT_W'(MOMENTUM_LAG)) && (lag_ff[4] != '0);
            task_in.mom_neg  = price_ff < lag_ff[4];
            task_in.dividend = DIVD_W'(mom_diff) * DIVD_W'(cfg.momentum_gain);
            task_in.divisor  = lag_ff[4];
            prod_g_in = PROD_W'(gain_ff) * PROD_W'(100);
            prod_o_in = PROD_W'(gl_sum) * PROD_W'(cfg.oversold_level);
            prod_b_in = PROD_W'(gl_sum) * PROD_W'(cfg.overbought_level);
            l_zero_in = loss_ff == '0;
            state_in  = F_PUSH;
         end
         F_PUSH: begin
            // RSI is 100 when there are no losses
            if (l_zero_ff) begin
               push_data.below = LEVEL_W'(100) < cfg.oversold_level;
               push_data.above = LEVEL_W'(100) > cfg.overbought_level;
            end else begin
               push_data.below = prod_g_ff < prod_o_ff;
               push_data.above = prod_g_ff > prod_b_ff;
            end
            if (!push_full) begin
               push_valid = 1'b1;
               state_in   = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         pos_ff   <= '0;
         count_ff <= '0;
         trend_ff <= '0;
         gain_ff  <= '0;
         loss_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         trend_ff <= trend_in;
         gain_ff  <= gain_in;
         loss_ff  <= loss_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      price_ff  <= price_in;
      before_ff <= before_in;
      task_ff   <= task_in;
      prod_g_ff <= prod_g_in;
      prod_o_ff <= prod_o_in;
      prod_b_ff <= prod_b_in;
      l_zero_ff <= l_zero_in;
      if (state_ff == F_READ && rd_idx_ff != '0) begin
         lag_ff[rd_idx_ff - 3'd1] <= ram_rdata;
      end
   end
endmodule

### sv/pis_queue.sv
// Short task queue between the front and back ends.
`timescale 1ns / 1ps
module pis_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  pis_pkg::task_type push_data,
   output logic              push_full,
   output logic              pop_valid,
   output pis_pkg::task_type pop_data,
   input  logic              pop
);
   import pis_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   task_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [FILL_W-1:0]   fill_ff;
   logic                do_push, do_pop;

   assign push_full = fill_ff == FILL_W'(QUEUE_DEPTH);
   assign pop_valid = fill_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         fill_ff <= fill_ff + FILL_W'(do_push) - FILL_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

### sv/pis_back.sv
// Back end: momentum divider, strength sum with saturation, decision and output register.
`timescale 1ns / 1ps
module pis_back (
   input  logic                              clock,
   input  logic                              reset,
   input  pis_pkg::cfg_type                  cfg,
   input  logic                              pop_valid,
   input  pis_pkg::task_type                 pop_data,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_ready_res,
   output logic signed [pis_pkg::STRENGTH_W-1:0] rsp_strength,
   output logic [pis_pkg::DECISION_W-1:0]    rsp_decision
);
   import pis_pkg::*;

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_DIV  = 2'd1;
   localparam logic [1:0] B_OUT  = 2'd2;
   localparam int STEP_W = $clog2(DIVD_W);
   localparam int ACC_W  = DIVD_W + 3;
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

   logic [1:0]         state_ff, state_in;
   task_type           task_ff, task_in;
   logic [DIVD_W-1:0]  quo_ff, quo_in;
   logic [PRICE_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               res_ready_ff, res_ready_in;
   logic signed [STRENGTH_W-1:0] strength_ff, strength_in;
   logic [DECISION_W-1:0] decision_ff, decision_in;

   logic [PRICE_W:0]   shifted, trial;
   logic               fits;
   logic signed [ACC_W-1:0] acc, t_term, r_term, m_term;
   logic signed [STRENGTH_W-1:0] sat;
   logic               out_free;

   assign shifted  = {rem_ff, quo_ff[DIVD_W-1]};
   assign trial    = shifted - {1'b0, task_ff.divisor};
   assign fits     = shifted >= {1'b0, task_ff.divisor};
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = (state_ff == B_IDLE) && pop_valid;

   always_comb begin
      t_term = task_ff.trend_up ? $signed(ACC_W'(cfg.trend_weight))
                                : -$signed(ACC_W'(cfg.trend_weight));
      if (task_ff.below) begin
         r_term = $signed(ACC_W'(cfg.rsi_weight));
      end else if (task_ff.above) begin
         r_term = -$signed(ACC_W'(cfg.rsi_weight));
      end else begin
         r_term = '0;
      end
      if (!task_ff.mom_en) begin
         m_term = '0;
      end else if (task_ff.mom_neg) begin
         m_term = -$signed(ACC_W'(quo_ff));
      end else begin
         m_term = $signed(ACC_W'(quo_ff));
      end
      acc = t_term + r_term + m_term;
      if (acc > SAT_HI) begin
         sat = STRENGTH_W'(SAT_HI);
      end else if (acc < SAT_LO) begin
         sat = STRENGTH_W'(SAT_LO);
      end else begin
         sat = STRENGTH_W'(acc);
      end
   end

   always_comb begin
      state_in     = state_ff;
      task_in      = task_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      res_ready_in = res_ready_ff;
      strength_in  = strength_ff;
      decision_in  = decision_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               task_in = pop_data;
               quo_in  = pop_data.dividend;
               rem_in  = '0;
               step_in = '0;
               state_in = (pop_data.ready && pop_data.mom_en) ? B_DIV : B_OUT;
            end
         end
         B_DIV: begin
            // restoring division, one quotient bit per cycle
            rem_in  = fits ? trial[PRICE_W-1:0] : shifted[PRICE_W-1:0];
            quo_in  = {quo_ff[DIVD_W-2:0], fits};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIVD_W - 1)) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               res_ready_in = task_ff.ready;
               if (task_ff.ready) begin
                  strength_in = sat;
                  if (sat > cfg.buy_level) begin
                     decision_in = DEC_BUY;
                  end else if (sat < cfg.sell_level) begin
                     decision_in = DEC_SELL;
                  end else begin
                     decision_in = DEC_HOLD;
                  end
               end else begin
                  strength_in = '0;
                  decision_in = DEC_HOLD;
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff      <= task_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      res_ready_ff <= res_ready_in;
      strength_ff  <= strength_in;
      decision_ff  <= decision_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ready_res = res_ready_ff;
   assign rsp_strength  = strength_ff;
   assign rsp_decision  = decision_ff;
endmodule
